>>> src/etf_pkg.sv
`timescale 1ns / 1ps

package etf_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 28;
  localparam int CNT_W      = 16;
  // z stays within +/-12.0 in Q.28, so 34 signed bits cover it; magnitudes fit 32 bits
  localparam int Z_W        = 34;
  localparam int MAG_W      = 32;
  localparam int SQ_W       = 2 * MAG_W - FRAC_BITS;
  localparam int LEN_W      = SQ_W + 1;
  localparam int LOG_STEPS  = 16;
  localparam int LOG_M_W    = 32;
  localparam int DIV_W      = CNT_W + 17;
  localparam int DIVISOR_W  = CNT_W;

  localparam logic [LEN_W-1:0] FOUR = LEN_W'(4) << FRAC_BITS;
  localparam logic [15:0]      SMOOTH_MAX = 16'hffff;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_LIMIT = 2'd1,
    REG_JRE   = 2'd2,
    REG_JIM   = 2'd3
  } etf_reg_t;

  typedef enum logic {
    MODE_MANDEL = 1'b0,
    MODE_JULIA  = 1'b1
  } etf_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_LOG1_GO,
    ST_LOG1_WAIT,
    ST_LOG2_GO,
    ST_LOG2_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } etf_state_t;

  // one beat travelling down the log2 squaring row
  typedef struct packed {
    logic               vld;
    logic [LOG_M_W-1:0] m;
    logic [15:0]        frac;
  } etf_log_beat_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [Z_W-1:0] v);
    logic [Z_W-1:0] a;
    a = v[Z_W-1] ? Z_W'(-v) : Z_W'(v);
    return a[MAG_W-1:0];
  endfunction

endpackage

>>> src/etf_log_cell.sv
`timescale 1ns / 1ps

// one squaring step of the log2 fraction: yields one result bit per cell
module etf_log_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  etf_pkg::etf_log_beat_t beat_in,
  output etf_pkg::etf_log_beat_t beat_out
);

  logic [2*etf_pkg::LOG_M_W-1:0] sq;
  logic [etf_pkg::LOG_M_W:0]     t;
  etf_pkg::etf_log_beat_t        beat_r;

  assign sq = beat_in.m * beat_in.m;
  assign t  = sq[2*etf_pkg::LOG_M_W-1:etf_pkg::LOG_M_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else begin
      beat_r.vld <= beat_in.vld;
    end
    beat_r.m    <= t[etf_pkg::LOG_M_W] ? t[etf_pkg::LOG_M_W:1] : t[etf_pkg::LOG_M_W-1:0];
    beat_r.frac <= {beat_in.frac[14:0], t[etf_pkg::LOG_M_W]};
  end

  assign beat_out = beat_r;

endmodule

>>> src/etf_log_chain.sv
`timescale 1ns / 1ps

// row of squaring cells; a mantissa in [1,2) enters, 16 fraction bits leave
module etf_log_chain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [etf_pkg::LOG_M_W-1:0]   m_in,
  output logic                          done,
  output logic [15:0]                   frac
);

  etf_pkg::etf_log_beat_t link [etf_pkg::LOG_STEPS+1];

  assign link[0].vld  = start;
  assign link[0].m    = m_in;
  assign link[0].frac = 16'd0;

  for (genvar g = 0; g < etf_pkg::LOG_STEPS; g++) begin : g_cell
    etf_log_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .beat_in  (link[g]),
      .beat_out (link[g+1])
    );
  end

  assign done = link[etf_pkg::LOG_STEPS].vld;
  assign frac = link[etf_pkg::LOG_STEPS].frac;

endmodule

>>> src/etf_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module etf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [etf_pkg::DIV_W-1:0]     dividend,
  input  logic [etf_pkg::DIVISOR_W-1:0] divisor,
  output logic                          done,
  output logic [etf_pkg::DIV_W-1:0]     quot
);

  localparam int CW = $clog2(etf_pkg::DIV_W + 1);

  logic                           busy_r;
  logic                           done_r;
  logic [CW-1:0]                  cnt_r;
  logic [etf_pkg::DIVISOR_W-1:0]  rem_r;
  logic [etf_pkg::DIV_W-1:0]      quo_r;
  logic [etf_pkg::DIVISOR_W:0]    trial;
  logic [etf_pkg::DIVISOR_W:0]    diff;
  logic                           ge;

  assign trial = {rem_r, quo_r[etf_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(etf_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? diff[etf_pkg::DIVISOR_W-1:0] : trial[etf_pkg::DIVISOR_W-1:0];
      quo_r <= {quo_r[etf_pkg::DIV_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

>>> src/escape_time_fractal_iterator.sv
`timescale 1ns / 1ps

// Channel | Dir | Signals                  | Beat contents
// in      | in  | in_tvalid/tready/tdata   | point_real, point_imag
// out     | out | out_tvalid/tready/tdata  | iteration_count, smooth_value; tuser escaped
// cfg     | in  | cfg_we/addr/wdata        | register write, no read-back
//
// One point is in flight at a time. Each iteration multiplies, then adds and runs the
// escape test. An escaping point, if the limit is nonzero, then passes twice
// through the 16-cell log2 row and, unless the smoothing numerator is not positive,
// through the divider. in_tready is high only while idle.
// Reset is synchronous, active low, and restores the register defaults.
// The output register holds a finished beat while a new point is iterated;
// the next result waits only if that beat has not been taken.
module escape_time_fractal_iterator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] point_real, [63:32] point_imag
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] iteration_count, [31:16] smooth_value
  output logic        out_tuser,  // [0] escaped
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int ZW  = etf_pkg::Z_W;
  localparam int SW  = etf_pkg::SQ_W;
  localparam int LW  = etf_pkg::LEN_W;
  localparam int MW  = etf_pkg::MAG_W;
  localparam int FB  = etf_pkg::FRAC_BITS;
  localparam int CNW = etf_pkg::CNT_W;

  // configuration
  logic                             mode_r;
  logic [CNW-1:0]                   limit_r;
  logic signed [etf_pkg::COORD_W-1:0] jre_r;
  logic signed [etf_pkg::COORD_W-1:0] jim_r;

  etf_pkg::etf_state_t state_r, state_nxt;

  // iteration datapath
  logic signed [ZW-1:0]             zx_r, zy_r;
  logic signed [etf_pkg::COORD_W-1:0] cx_r, cy_r;
  logic [CNW-1:0]                   iter_r;
  logic [SW-1:0]                    sqx_r, sqy_r;
  logic signed [SW:0]               xy_r;
  logic [LW-1:0]                    len2_r;
  logic                             esc_r;
  logic [3:0]                       ip_r;
  logic [19:0]                      l1_r;
  logic [15:0]                      smooth_r;

  // output register
  logic                             out_vld_r;
  logic [CNW-1:0]                   out_cnt_r;
  logic                             out_esc_r;
  logic [15:0]                      out_smooth_r;

  // control strobes
  logic log_go, div_go, out_load;

  // combinational terms
  logic [MW-1:0]          zx_mag, zy_mag;
  logic [2*MW-1:0]        pxx, pyy, pxy;
  logic [LW-1:0]          len2;
  logic                   esc_now, go_on;
  logic signed [ZW+3:0]   nx_w, ny_w;
  logic [5:0]             msb1;
  logic [etf_pkg::LOG_M_W-1:0] m1;
  logic [4:0]             msb2;
  logic [etf_pkg::LOG_M_W-1:0] m2;
  logic [etf_pkg::LOG_M_W-1:0] log_m;
  logic                   log_done;
  logic [15:0]            log_frac;
  logic [17:0]            l2;
  logic signed [etf_pkg::DIV_W:0] s_w;
  logic                   s_nonpos;
  logic                   div_done;
  logic [etf_pkg::DIV_W-1:0] quot;

  // ---- configuration port ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= etf_pkg::MODE_MANDEL;
      limit_r <= CNW'(256);
      jre_r   <= '0;
      jim_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        etf_pkg::REG_MODE:  mode_r  <= cfg_wdata[0];
        etf_pkg::REG_LIMIT: limit_r <= cfg_wdata[CNW-1:0];
        etf_pkg::REG_JRE:   jre_r   <= cfg_wdata;
        etf_pkg::REG_JIM:   jim_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- iteration arithmetic ----
  assign zx_mag = etf_pkg::mag(zx_r);
  assign zy_mag = etf_pkg::mag(zy_r);
  assign pxx    = zx_mag * zx_mag;
  assign pyy    = zy_mag * zy_mag;
  assign pxy    = zx_mag * zy_mag;

  // squares of z never saturate: each part of z stays below 12.0 in magnitude whenever it is squared
  assign len2    = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign esc_now = len2 >= etf_pkg::FOUR;
  assign go_on   = !esc_now && (iter_r < limit_r);
  assign nx_w    = $signed({2'b0, sqx_r}) - $signed({2'b0, sqy_r}) + (ZW+4)'(cx_r);
  assign ny_w    = (ZW+4)'(xy_r) + (ZW+4)'(xy_r) + (ZW+4)'(cy_r);

  // ---- log2 normalisation: |z|^2 >= 4.0, so its top bit sits at 30..36 ----
  always_comb begin
    msb1 = 6'd30;
    for (int i = 31; i < LW; i++) begin
      if (len2_r[i]) msb1 = 6'(i);
    end
    if (msb1 == 6'd30) begin
      m1 = {len2_r[30:0], 1'b0};
    end else begin
      m1 = etf_pkg::LOG_M_W'(len2_r >> (msb1 - 6'd31));
    end
  end

  // first log lies in [2.0, 10.0), so its top bit sits at 17..19
  always_comb begin
    msb2 = 5'd17;
    for (int i = 18; i < 20; i++) begin
      if (l1_r[i]) msb2 = 5'(i);
    end
    m2 = etf_pkg::LOG_M_W'(l1_r) << (5'd31 - msb2);
  end

  assign log_m = (state_r == etf_pkg::ST_LOG1_GO) ? m1 : m2;

  etf_log_chain u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_go),
    .m_in  (log_m),
    .done  (log_done),
    .frac  (log_frac)
  );

  // second log straight off the row when it lands, held in l1_r afterwards
  assign l2       = (state_r == etf_pkg::ST_LOG2_WAIT) ? {ip_r[1:0], log_frac} : l1_r[17:0];
  assign s_w      = $signed({1'b0, {1'b0, iter_r} + 17'd1, 16'd0}) -
                    $signed({(etf_pkg::DIV_W - 17)'(0), l2});
  assign s_nonpos = s_w[etf_pkg::DIV_W] || (s_w == '0);

  etf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (s_w[etf_pkg::DIV_W-1:0]),
    .divisor  (limit_r),
    .done     (div_done),
    .quot     (quot)
  );

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      etf_pkg::ST_IDLE:      if (in_tvalid) state_nxt = etf_pkg::ST_MUL;
      etf_pkg::ST_MUL:       state_nxt = etf_pkg::ST_ADD;
      etf_pkg::ST_ADD: begin
        if (go_on)                            state_nxt = etf_pkg::ST_MUL;
        else if (esc_now && limit_r != '0)    state_nxt = etf_pkg::ST_LOG1_GO;
        else                                  state_nxt = etf_pkg::ST_OUT;
      end
      etf_pkg::ST_LOG1_GO:   state_nxt = etf_pkg::ST_LOG1_WAIT;
      etf_pkg::ST_LOG1_WAIT: if (log_done) state_nxt = etf_pkg::ST_LOG2_GO;
      etf_pkg::ST_LOG2_GO:   state_nxt = etf_pkg::ST_LOG2_WAIT;
      etf_pkg::ST_LOG2_WAIT: begin
        if (log_done) state_nxt = s_nonpos ? etf_pkg::ST_OUT : etf_pkg::ST_DIV_GO;
      end
      etf_pkg::ST_DIV_GO:    state_nxt = etf_pkg::ST_DIV_WAIT;
      etf_pkg::ST_DIV_WAIT:  if (div_done) state_nxt = etf_pkg::ST_OUT;
      etf_pkg::ST_OUT:       if (!out_vld_r || out_tready) state_nxt = etf_pkg::ST_IDLE;
      default:               state_nxt = etf_pkg::ST_IDLE;
    endcase
  end

  // ---- control outputs ----
  always_comb begin
    in_tready = (state_r == etf_pkg::ST_IDLE);
    log_go    = (state_r == etf_pkg::ST_LOG1_GO) || (state_r == etf_pkg::ST_LOG2_GO);
    div_go    = (state_r == etf_pkg::ST_DIV_GO);
    out_load  = (state_r == etf_pkg::ST_OUT) && (!out_vld_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= etf_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)                     out_vld_r <= 1'b1;
      else if (out_tready)              out_vld_r <= 1'b0;
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    case (state_r)
      etf_pkg::ST_IDLE: begin
        iter_r <= '0;
        if (mode_r == etf_pkg::MODE_JULIA) begin
          zx_r <= ZW'($signed(in_tdata[31:0]));
          zy_r <= ZW'($signed(in_tdata[63:32]));
          cx_r <= jre_r;
          cy_r <= jim_r;
        end else begin
          zx_r <= '0;
          zy_r <= '0;
          cx_r <= in_tdata[31:0];
          cy_r <= in_tdata[63:32];
        end
      end
      etf_pkg::ST_MUL: begin
        sqx_r <= pxx[2*MW-1:FB];
        sqy_r <= pyy[2*MW-1:FB];
        xy_r  <= (zx_r[ZW-1] ^ zy_r[ZW-1]) ? -$signed({1'b0, pxy[2*MW-1:FB]})
                                           :  $signed({1'b0, pxy[2*MW-1:FB]});
      end
      etf_pkg::ST_ADD: begin
        len2_r   <= len2;
        esc_r    <= esc_now;
        smooth_r <= etf_pkg::SMOOTH_MAX;
        if (go_on) begin
          zx_r   <= nx_w[ZW-1:0];
          zy_r   <= ny_w[ZW-1:0];
          iter_r <= iter_r + 1'b1;
        end
      end
      etf_pkg::ST_LOG1_GO: ip_r <= 4'(msb1 - 6'd28);
      etf_pkg::ST_LOG1_WAIT: if (log_done) l1_r <= {ip_r, log_frac};
      etf_pkg::ST_LOG2_GO: ip_r <= 4'(msb2 - 5'd16);
      etf_pkg::ST_LOG2_WAIT: begin
        if (log_done) begin
          l1_r <= {ip_r, log_frac};
          if (s_nonpos) smooth_r <= '0;
        end
      end
      etf_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          smooth_r <= (quot > etf_pkg::DIV_W'(etf_pkg::SMOOTH_MAX)) ? etf_pkg::SMOOTH_MAX
                                                                    : quot[15:0];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_cnt_r    <= iter_r;
      out_esc_r    <= esc_r;
      out_smooth_r <= smooth_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_smooth_r, out_cnt_r};
  assign out_tuser  = out_esc_r;

endmodule

>>> src/etf_checker.sv
`timescale 1ns / 1ps

module etf_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // a beat that is offered stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out beat withdrawn before taken");

  // a point that never escaped reads as full scale
  a_inside_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:16] == 16'hffff)
    else $error("inside point without full-scale smooth value");

  // one point at a time: ready drops after a point is taken
  a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second point taken while iterating");

  // nothing is offered straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out beat valid after reset");

endmodule

bind escape_time_fractal_iterator etf_port_checker u_etf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> dv/etf_checker.sv
`timescale 1ns / 1ps

module etf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] point_real, [63:32] point_imag
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [15:0] iteration_count, [31:16] smooth_value
  input  logic        out_tuser,  // [0] escaped
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [15:0] count;
    logic        escaped;
    logic [15:0] smooth;
  } escape_result_t;

  localparam longint S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

  etf_pkg::etf_mode_t sh_mode;
  logic [15:0]        sh_limit;
  logic signed [31:0] sh_jre, sh_jim;
  escape_result_t     escape_q[$];

  function automatic longint clamp66(input logic signed [65:0] v);
    if (v > 66'(S64_MAX)) return S64_MAX;
    if (v < 66'(S64_MIN)) return S64_MIN;
    return v[63:0];
  endfunction

  function automatic longint qadd(input longint a, input longint b);
    return clamp66(66'(a) + 66'(b));
  endfunction

  function automatic longint qsub(input longint a, input longint b);
    return clamp66(66'(a) - 66'(b));
  endfunction

  // exact product, truncated toward zero, saturated
  function automatic longint qmul(input longint a, input longint b);
    logic [63:0]  ua, ub;
    logic [127:0] p;
    logic         neg;
    ua  = a < 0 ? 64'(-a) : 64'(a);
    ub  = b < 0 ? 64'(-b) : 64'(b);
    neg = (a < 0) != (b < 0);
    p   = ({64'd0, ua} * {64'd0, ub}) >> etf_pkg::FRAC_BITS;
    if (p > 128'(S64_MAX)) return neg ? S64_MIN : S64_MAX;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // log2 in Q.16 by repeated squaring of a 32-bit mantissa
  function automatic longint log2_q16(input logic [63:0] x, input int fbits);
    int          msb;
    logic [63:0] m;
    logic [15:0] frac;
    msb  = 63;
    frac = '0;
    while (msb > 0 && !x[msb]) msb--;
    m = msb >= 31 ? x >> (msb - 31) : x << (31 - msb);
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m       = m >> 1;
      end
    end
    return longint'(msb - fbits) * 65536 + longint'(frac);
  endfunction

  function automatic escape_result_t escape_point(input logic signed [31:0] px,
                                                  input logic signed [31:0] py);
    longint         zx, zy, cx, cy, len2, nx, xy, four, l1, l2, s, q;
    int unsigned    iter;
    escape_result_t r;
    four = longint'(4) <<< etf_pkg::FRAC_BITS;
    iter = 0;
    if (sh_mode == etf_pkg::MODE_JULIA) begin
      zx = px; zy = py; cx = sh_jre; cy = sh_jim;
    end else begin
      zx = 0; zy = 0; cx = px; cy = py;
    end
    len2 = qadd(qmul(zx, zx), qmul(zy, zy));
    while (len2 < four && iter < sh_limit) begin
      nx   = qadd(qsub(qmul(zx, zx), qmul(zy, zy)), cx);
      xy   = qmul(zx, zy);
      zy   = qadd(qadd(xy, xy), cy);
      zx   = nx;
      iter++;
      len2 = qadd(qmul(zx, zx), qmul(zy, zy));
    end
    r.count   = iter[15:0];
    r.escaped = len2 >= four;
    r.smooth  = etf_pkg::SMOOTH_MAX;
    if (r.escaped && sh_limit != 0) begin
      l1 = log2_q16(64'(len2), etf_pkg::FRAC_BITS);
      l2 = log2_q16(64'(l1), 16);
      s  = longint'(iter + 1) * 65536 - l2;
      if (s <= 0) begin
        r.smooth = '0;
      end else begin
        q        = s / longint'(sh_limit);
        r.smooth = q > 65535 ? etf_pkg::SMOOTH_MAX : q[15:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    escape_result_t e, got;
    if (!rst_n) begin
      sh_mode  <= etf_pkg::MODE_MANDEL;
      sh_limit <= 16'd256;
      sh_jre   <= '0;
      sh_jim   <= '0;
      errors   <= 0;
    end else begin
      if (cfg_we) begin
        case (etf_pkg::etf_reg_t'(cfg_addr))
          etf_pkg::REG_MODE:  sh_mode  <= etf_pkg::etf_mode_t'(cfg_wdata[0]);
          etf_pkg::REG_LIMIT: sh_limit <= cfg_wdata[15:0];
          etf_pkg::REG_JRE:   sh_jre   <= cfg_wdata;
          etf_pkg::REG_JIM:   sh_jim   <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        escape_q.push_back(escape_point(in_tdata[31:0], in_tdata[63:32]));
      if (out_tvalid && out_tready) begin
        got = '{count: out_tdata[15:0], escaped: out_tuser, smooth: out_tdata[31:16]};
        if (escape_q.size() == 0) begin
          $display("%0t: unexpected result beat count=%0d esc=%0b smooth=%0d",
                   $time, got.count, got.escaped, got.smooth);
          errors <= errors + 1;
        end else begin
          e = escape_q.pop_front();
          if (got != e) begin
            $display("%0t: result mismatch, expected count=%0d esc=%0b smooth=%0d,",
                     $time, e.count, e.escaped, e.smooth);
            $display("%0t:   actual count=%0d esc=%0b smooth=%0d",
                     $time, got.count, got.escaped, got.smooth);
            errors <= errors + 1;
          end
        end
      end
    end
    pending = escape_q.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // generous: ~400 points at <=1000 iterations, plus full-depth points and a long hold
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN       = 200;

  // Q4.28 helpers
  localparam logic [31:0] Q_ONE     = 32'h1000_0000;
  localparam logic [31:0] Q_TWO     = 32'h2000_0000;
  localparam logic [31:0] Q_M_TWO   = 32'he000_0000;
  localparam logic [31:0] Q_QUARTER = 32'h0400_0000;
  localparam logic [31:0] S32_MAX   = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN   = 32'h8000_0000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  int          errors, pending;

  bit rx_hold_req;   // ask the receiver for one long back-pressure stretch
  bit tx_no_gaps;    // sender offers beats back to back

  escape_time_fractal_iterator dut (.*);

  etf_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_we, .cfg_addr, .cfg_wdata, .errors, .pending
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // receiver: random stalls, free-running stretches, one long hold on request
  initial begin
    int r;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (1500) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(100, 400)) @(posedge clk);
        end else if (r < 60) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (pick_gap()) @(posedge clk);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("escape_time_fractal_iterator regression: fail");
    $finish;
  end

  task automatic send_point(input logic [31:0] re, input logic [31:0] im);
    int g;
    g = tx_no_gaps ? 0 : pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom};
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {im, re};
    do @(posedge clk); while (!in_tready);
  endtask

  // blocks until every expected beat is back; the block then sits idle
  task automatic drain();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input etf_pkg::etf_reg_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(input etf_pkg::etf_mode_t m, input logic [15:0] lim,
                       input logic [31:0] jr, input logic [31:0] ji);
    drain();
    write_reg(etf_pkg::REG_MODE, {$urandom_range(0, 1) ? 31'h7fff_ffff : 31'd0, m});
    write_reg(etf_pkg::REG_LIMIT, {16'($urandom), lim});
    write_reg(etf_pkg::REG_JRE, jr);
    write_reg(etf_pkg::REG_JIM, ji);
  endtask

  // most points land near the set (|x|,|y| < 2), the rest use the whole range
  task automatic random_points(input int n);
    logic [31:0] re, im;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        re = $signed($urandom) >>> 2;
        im = $signed($urandom) >>> 3;
      end else begin
        re = $urandom;
        im = $urandom;
      end
      send_point(re, im);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_we      = 1'b0;
    cfg_addr    = etf_pkg::REG_MODE;
    cfg_wdata   = '0;
    rx_hold_req = 1'b0;
    tx_no_gaps  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings: Mandelbrot, limit 256
    send_point('0, '0);                 // inside, runs to the limit
    send_point(S32_MAX, S32_MAX);
    send_point(S32_MIN, S32_MIN);
    send_point(S32_MIN, '0);
    send_point(Q_M_TWO, '0);            // tip of the set, |z|^2 lands exactly on 4.0
    send_point(Q_QUARTER, '0);          // cusp, slow convergence
    send_point(Q_TWO, '0);
    send_point(Q_ONE, Q_ONE);
    send_point(32'hf400_0000, 32'h0199_999a);

    // single iteration
    setup(etf_pkg::MODE_MANDEL, 16'd1, '0, '0);
    send_point('0, '0);
    send_point(Q_ONE, Q_ONE);
    send_point(S32_MAX, S32_MIN);

    // no iterations at all: escaped follows the starting z
    setup(etf_pkg::MODE_JULIA, 16'd0, '0, '0);
    send_point('0, '0);
    send_point(32'h3000_0000, '0);

    // Julia, starting point already outside, and the extreme constants
    setup(etf_pkg::MODE_JULIA, 16'd64, S32_MAX, S32_MIN);
    send_point(32'h3000_0000, '0);
    send_point('0, '0);
    send_point(S32_MIN, S32_MAX);
    setup(etf_pkg::MODE_JULIA, 16'd64, S32_MIN, S32_MAX);
    send_point(Q_QUARTER, Q_QUARTER);
    send_point(S32_MAX, S32_MAX);

    // deepest limit, points that never escape
    setup(etf_pkg::MODE_MANDEL, 16'hffff, '0, '0);
    send_point('0, '0);
    send_point(32'hfc00_0000, 32'h0a00_0000);

    // random phases over several settings
    setup(etf_pkg::MODE_MANDEL, 16'd256, '0, '0);
    random_points(60);
    rx_hold_req = 1'b1;                 // block fills and stalls its input
    random_points(20);

    setup(etf_pkg::MODE_JULIA, 16'd100, 32'hf333_3333, 32'h027e_f9db);  // -0.8 + 0.156i
    random_points(60);

    setup(etf_pkg::MODE_MANDEL, 16'd16, '0, '0);
    tx_no_gaps = 1'b1;
    random_points(50);
    tx_no_gaps = 1'b0;

    setup(etf_pkg::MODE_JULIA, 16'd300, $urandom, $urandom);
    random_points(30);
    drain();                            // sender waits for every result
    random_points(30);

    setup(etf_pkg::MODE_MANDEL, 16'd2, '0, '0);
    random_points(40);

    setup(etf_pkg::MODE_JULIA, 16'd48, 32'h0451_eb85, 32'hf6b8_51ec);   // 0.27 - 0.58i
    random_points(60);

    setup(etf_pkg::MODE_MANDEL, 16'd1000, '0, '0);
    random_points(20);

    drain();
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("escape_time_fractal_iterator regression: pass");
    else
      $display("escape_time_fractal_iterator regression: fail");
    $finish;
  end

endmodule
